>>> rtl/assert_macros.svh
// Assertion helpers for the segment intersection checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/sip_pkg.sv
package sip_pkg;

  localparam int CoordW = 24;
  localparam int DiffW = 25;
  localparam int CrossW = 52;
  localparam int QuotW = 17;
  localparam int TFrac = 16;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [CrossW-1:0] cross_t;

  typedef struct packed {
    logic ok;
    logic [QuotW-1:0] q;
    logic [CrossW-1:0] r;
    logic [CrossW-1:0] d;
  } div_slot_t;

endpackage

>>> rtl/sip_divider.sv
module sip_divider
  import sip_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_vld,
  input  logic in_ok,
  input  logic [CrossW-1:0] in_num,
  input  logic [CrossW-1:0] in_den,
  input  coord_t in_ax,
  input  coord_t in_ay,
  input  diff_t in_dx,
  input  diff_t in_dy,
  output logic out_vld,
  output logic out_ok,
  output logic [QuotW-1:0] out_q,
  output coord_t out_ax,
  output coord_t out_ay,
  output diff_t out_dx,
  output diff_t out_dy
);

  localparam int Steps = QuotW;

  logic [Steps-1:0] vld_r;
  div_slot_t slot_r [Steps];
  coord_t ax_r [Steps];
  coord_t ay_r [Steps];
  diff_t dx_r [Steps];
  diff_t dy_r [Steps];

  function automatic div_slot_t div_step(div_slot_t s, logic first);
    div_slot_t o;
    logic [CrossW:0] rr;
    o = s;
    rr = first ? {1'b0, s.r} : {s.r, 1'b0};
    if (rr >= {1'b0, s.d}) begin
      rr = rr - {1'b0, s.d};
      o.q = {s.q[QuotW-2:0], 1'b1};
    end else begin
      o.q = {s.q[QuotW-2:0], 1'b0};
    end
    o.r = rr[CrossW-1:0];
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Steps-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slot_r[0] <= div_step('{ok: in_ok, q: '0, r: in_num, d: in_den}, 1'b1);
      ax_r[0] <= in_ax;
      ay_r[0] <= in_ay;
      dx_r[0] <= in_dx;
      dy_r[0] <= in_dy;
      for (int i = 1; i < Steps; i++) begin
        slot_r[i] <= div_step(slot_r[i-1], 1'b0);
        ax_r[i] <= ax_r[i-1];
        ay_r[i] <= ay_r[i-1];
        dx_r[i] <= dx_r[i-1];
        dy_r[i] <= dy_r[i-1];
      end
    end
  end

  assign out_vld = vld_r[Steps-1];
  assign out_ok = slot_r[Steps-1].ok;
  assign out_q = slot_r[Steps-1].q;
  assign out_ax = ax_r[Steps-1];
  assign out_ay = ay_r[Steps-1];
  assign out_dx = dx_r[Steps-1];
  assign out_dy = dy_r[Steps-1];

endmodule

>>> rtl/segment_intersection_point.sv
// Throughput: one word per cycle; the pipeline of 22 stages, 17 of them one
// restoring divide step each, advances whenever the output stage is free.
// Reset: synchronous active-low rst_n clears all valid bits; data registers
// are not reset.
module segment_intersection_point
  import sip_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  coord_t in_a_x,
  input  coord_t in_a_y,
  input  coord_t in_b_x,
  input  coord_t in_b_y,
  input  coord_t in_c_x,
  input  coord_t in_c_y,
  input  coord_t in_d_x,
  input  coord_t in_d_y,
  output logic out_valid,
  input  logic out_stall,
  output logic out_hit,
  output coord_t out_point_x,
  output coord_t out_point_y
);

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: differences.
  logic v1_r;
  diff_t abx_r, aby_r, cdx_r, cdy_r, acx_r, acy_r, adx_r, ady_r, bcx_r, bcy_r;
  diff_t bax_r, bay_r;
  coord_t ax1_r, ay1_r;

  // Stage 2: products.
  logic v2_r;
  cross_t p_r [12];
  coord_t ax2_r, ay2_r;
  diff_t bax2_r, bay2_r;

  // Stage 3: cross products and checks.
  logic v3_r, ok3_r;
  logic [CrossW-1:0] n3_r, d3_r;
  coord_t ax3_r, ay3_r;
  diff_t bax3_r, bay3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      abx_r <= DiffW'(in_a_x) - DiffW'(in_b_x);
      aby_r <= DiffW'(in_a_y) - DiffW'(in_b_y);
      cdx_r <= DiffW'(in_c_x) - DiffW'(in_d_x);
      cdy_r <= DiffW'(in_c_y) - DiffW'(in_d_y);
      acx_r <= DiffW'(in_a_x) - DiffW'(in_c_x);
      acy_r <= DiffW'(in_a_y) - DiffW'(in_c_y);
      adx_r <= DiffW'(in_a_x) - DiffW'(in_d_x);
      ady_r <= DiffW'(in_a_y) - DiffW'(in_d_y);
      bcx_r <= DiffW'(in_c_x) - DiffW'(in_b_x);
      bcy_r <= DiffW'(in_c_y) - DiffW'(in_b_y);
      bax_r <= DiffW'(in_b_x) - DiffW'(in_a_x);
      bay_r <= DiffW'(in_b_y) - DiffW'(in_a_y);
      ax1_r <= in_a_x;
      ay1_r <= in_a_y;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= CrossW'(abx_r * acy_r);
      p_r[1] <= CrossW'(aby_r * acx_r);
      p_r[2] <= CrossW'(abx_r * ady_r);
      p_r[3] <= CrossW'(aby_r * adx_r);
      p_r[4] <= CrossW'(cdx_r * (-acy_r));
      p_r[5] <= CrossW'(cdy_r * (-acx_r));
      p_r[6] <= CrossW'(cdx_r * bcy_r);
      p_r[7] <= CrossW'(cdy_r * bcx_r);
      p_r[8] <= CrossW'(abx_r * cdy_r);
      p_r[9] <= CrossW'(aby_r * cdx_r);
      p_r[10] <= CrossW'(acx_r * cdy_r);
      p_r[11] <= CrossW'(acy_r * cdx_r);
      ax2_r <= ax1_r;
      ay2_r <= ay1_r;
      bax2_r <= bax_r;
      bay2_r <= bay_r;
    end
  end

  cross_t s1, s2, s3, s4, den, tn, un;
  logic ok_nxt;
  always_comb begin
    s1 = p_r[0] - p_r[1];
    s2 = p_r[2] - p_r[3];
    s3 = p_r[4] - p_r[5];
    s4 = p_r[6] - p_r[7];
    den = p_r[8] - p_r[9];
    tn = p_r[10] - p_r[11];
    un = -s1;
    ok_nxt = 1'b1;
    if ((s1 != 0) && (s2 != 0) && (s1[CrossW-1] == s2[CrossW-1])) ok_nxt = 1'b0;
    if ((s3 != 0) && (s4 != 0) && (s3[CrossW-1] == s4[CrossW-1])) ok_nxt = 1'b0;
    if (den == 0) ok_nxt = 1'b0;
    if (den > 0) begin
      if (tn < 0 || tn > den || un < 0 || un > den) ok_nxt = 1'b0;
    end else begin
      if (tn > 0 || tn < den || un > 0 || un < den) ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok3_r <= ok_nxt;
      n3_r <= tn[CrossW-1] ? -tn : tn;
      d3_r <= ok_nxt ? (den[CrossW-1] ? -den : den) : CrossW'(1);
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      bax3_r <= bax2_r;
      bay3_r <= bay2_r;
    end
  end

  logic dv_vld, dv_ok;
  logic [QuotW-1:0] dv_q;
  coord_t dv_ax, dv_ay;
  diff_t dv_dx, dv_dy;

  sip_divider u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(v3_r), .in_ok(ok3_r), .in_num(n3_r), .in_den(d3_r),
    .in_ax(ax3_r), .in_ay(ay3_r), .in_dx(bax3_r), .in_dy(bay3_r),
    .out_vld(dv_vld), .out_ok(dv_ok), .out_q(dv_q),
    .out_ax(dv_ax), .out_ay(dv_ay), .out_dx(dv_dx), .out_dy(dv_dy)
  );

  // Scale stage, then final add.
  logic v5_r, ok5_r;
  logic signed [QuotW+DiffW:0] mx_r, my_r;
  coord_t ax5_r, ay5_r;
  logic v6_r;
  logic hit_r;
  coord_t px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v5_r <= dv_vld;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok5_r <= dv_ok;
      mx_r <= $signed({1'b0, dv_q}) * dv_dx;
      my_r <= $signed({1'b0, dv_q}) * dv_dy;
      ax5_r <= dv_ax;
      ay5_r <= dv_ay;
      hit_r <= ok5_r;
      px_r <= ok5_r ? CoordW'(ax5_r + CoordW'(mx_r >>> TFrac)) : '0;
      py_r <= ok5_r ? CoordW'(ay5_r + CoordW'(my_r >>> TFrac)) : '0;
    end
  end

  assign out_valid = v6_r;
  assign out_hit = hit_r;
  assign out_point_x = px_r;
  assign out_point_y = py_r;

endmodule

>>> rtl/sip_checker.sv
module sip_checker
  import sip_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_hit,
  input coord_t out_point_x,
  input coord_t out_point_y
);
`include "assert_macros.svh"

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "Stalled word dropped.")
  `ASSERT_CLK(a_miss_zero, out_valid && !out_hit |-> out_point_x == 0 && out_point_y == 0, "Miss.")
  `ASSERT_CLK(a_stall_link, in_stall |-> out_valid && out_stall, "Input stall without output stall.")
  `ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "Output valid right after reset.")

endmodule

bind segment_intersection_point sip_checker u_sip_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
  .out_point_x(out_point_x), .out_point_y(out_point_y)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb
  import sip_pkg::*;
();

  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
  } seg_pair_t;

  typedef struct packed {
    logic hit;
    coord_t px, py;
  } crossing_t;

  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_a_x = '0, in_a_y = '0, in_b_x = '0, in_b_y = '0;
  coord_t in_c_x = '0, in_c_y = '0, in_d_x = '0, in_d_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  coord_t out_point_x, out_point_y;

  seg_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];
  int send_idle_pct = 8;
  int recv_idle_pct = 88;
  int errors = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  segment_intersection_point dut (.*);

  function automatic longint cross_of(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  function automatic longint floor16(longint p);
    return p >>> 16;
  endfunction

  function automatic crossing_t find_crossing(seg_pair_t s);
    crossing_t res;
    longint ax, ay, bx, by, cx, cy, dx, dy;
    longint abx, aby, cdx, cdy, s1, s2, s3, s4, den, tn, un, n, d, q, r;
    ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
    cx = s.cx; cy = s.cy; dx = s.dx; dy = s.dy;
    res = '0;
    abx = ax - bx; aby = ay - by; cdx = cx - dx; cdy = cy - dy;
    s1 = cross_of(abx, aby, ax - cx, ay - cy);
    s2 = cross_of(abx, aby, ax - dx, ay - dy);
    s3 = cross_of(cdx, cdy, cx - ax, cy - ay);
    s4 = cross_of(cdx, cdy, cx - bx, cy - by);
    if ((s1 > 0 && s2 > 0) || (s1 < 0 && s2 < 0)) return res;
    if ((s3 > 0 && s4 > 0) || (s3 < 0 && s4 < 0)) return res;
    den = cross_of(abx, aby, cdx, cdy);
    if (den == 0) return res;
    tn = cross_of(ax - cx, ay - cy, cdx, cdy);
    un = cross_of(abx, aby, cx - ax, cy - ay);
    if (den > 0) begin
      if (tn < 0 || tn > den || un < 0 || un > den) return res;
    end else begin
      if (tn > 0 || tn < den || un > 0 || un < den) return res;
    end
    n = tn < 0 ? -tn : tn;
    d = den < 0 ? -den : den;
    q = 0;
    r = n;
    if (r >= d) begin
      q = 1;
      r -= d;
    end
    for (int i = 0; i < 16; i++) begin
      r = r <<< 1;
      q = q <<< 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
    end
    res.hit = 1'b1;
    res.px = coord_t'(ax + floor16(q * (bx - ax)));
    res.py = coord_t'(ay + floor16(q * (by - ay)));
    return res;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 4095)) - 2048);
      default: return coord_t'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t s;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      mode = mode < 3 ? 0 : (mode < 7 ? 1 : 2);
      s.ax = rand_coord(mode); s.ay = rand_coord(mode);
      s.bx = rand_coord(mode); s.by = rand_coord(mode);
      s.cx = rand_coord(mode); s.cy = rand_coord(mode);
      s.dx = rand_coord(mode); s.dy = rand_coord(mode);
      if ($urandom_range(0, 9) == 0) s.cx = s.ax;
      if ($urandom_range(0, 9) == 0) begin
        s.dx = s.cx + (s.bx - s.ax);
        s.dy = s.cy + (s.by - s.ay);
      end
    end
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_crossings = {expected_crossings,
                              find_crossing({in_a_x, in_a_y, in_b_x, in_b_y,
                                             in_c_x, in_c_y, in_d_x, in_d_y})};
      end
      if (!in_valid || !in_stall) begin
        if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          seg_pair_t s;
          s = pending_pairs.pop_front();
          {in_a_x, in_a_y, in_b_x, in_b_y, in_c_x, in_c_y, in_d_x, in_d_y} <= s;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= $urandom_range(0, 99) < recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("status: fail");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_crossings.size() == 0) begin
          $error("result word with no expected result");
          errors = errors + 1;
        end else begin
          crossing_t e;
          e = expected_crossings.pop_front();
          if (out_hit !== e.hit) begin
            $error("hit expected %0d actual %0d", e.hit, out_hit);
            errors = errors + 1;
          end
          if (out_point_x !== e.px) begin
            $error("point_x expected %0d actual %0d", e.px, out_point_x);
            errors = errors + 1;
          end
          if (out_point_y !== e.py) begin
            $error("point_y expected %0d actual %0d", e.py, out_point_y);
            errors = errors + 1;
          end
        end
      end
    end
  end

  task automatic add_pair(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
    pending_pairs = {pending_pairs,
                     seg_pair_t'({coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by),
                                  coord_t'(cx), coord_t'(cy), coord_t'(dx), coord_t'(dy)})};
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_crossings.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    add_pair(0, 0, 256, 256, 0, 256, 256, 0);
    add_pair(0, 0, 256, 0, 0, 256, 256, 256);
    add_pair(0, 0, 256, 0, 512, 0, 768, 0);
    add_pair(0, 0, 256, 0, 128, 0, 512, 0);
    add_pair(0, 0, 256, 256, 256, 0, 512, -256);
    add_pair(0, 0, 256, 0, 128, 0, 128, 256);
    add_pair(0, 0, 256, 0, 256, -256, 256, 256);
    add_pair(0, 0, 256, 0, 300, -256, 300, 256);
    add_pair(0, 0, 256, 0, 128, 10, 128, 256);
    add_pair(mn, mn, mx, mx, mn, mx, mx, mn);
    add_pair(mx, mn, mn, mx, mn, mn, mx, mx);
    add_pair(mn, 0, mx, 0, 0, mn, 0, mx);
    add_pair(mx, mx, mx, mx, mx, mx, mx, mx);
    add_pair(mn, mn, mn, mn, mn, mn, mn, mn);
    add_pair(-1, -1, 1, 1, -1, 1, 1, -1);
    add_pair(0, 0, 3, 0, 1, -7, 2, 5);
    add_pair(-5, -3, -300, 700, -400, -100, 200, 900);
    add_pair(10, 10, 10, 10, 0, 0, 20, 20);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 8 : (phase == 1 ? 88 : 0);
      recv_idle_pct = phase == 0 ? 88 : (phase == 1 ? 8 : 0);
      for (int i = 0; i < 170; i++) pending_pairs = {pending_pairs, rand_pair()};
      drain();
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_crossings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
